FILE: design/ihq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_pkg: shared types and constants of the interval max-heap queue
// Record layout, request and status codes, and the heap geometry.
// ----------------------------------------------------------------------------
package ihq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index 2*pos+2 needs room for twice the address range
	localparam int IDX_W    = ADDR_W + 2;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_EXTRACT = 2'd1;
	localparam logic [1:0] REQ_PEEK    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] key;
		logic [31:0]        point_left;
		logic [31:0]        point_right;
		logic [31:0]        value_left;
		logic [31:0]        value_right;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic [1:0]       status;
		rec_t             rec;
		logic [CNT_W-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		rec_t              wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} ram_req_t;

endpackage

FILE: design/ihq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_ram: one write port, two read ports, registered read data
// Plain synchronous memory; a read returns the contents before a same-cycle write.
// ----------------------------------------------------------------------------
module ihq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH),
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_a,
	output logic [W-1:0]  rdata_b
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: design/ihq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_out: response staging
// A pending slot in front of the output register, so the controller can
// drop a result and go on sifting while the previous result is still held.
// ----------------------------------------------------------------------------
module ihq_out import ihq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_data,
	output logic pend_busy,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	logic pend_q;
	rsp_t pend_data_q;
	logic vld_q;
	rsp_t out_data_q;
	logic move;

	assign move      = pend_q && (!vld_q || rsp_ready);
	assign pend_busy = pend_q;
	assign rsp_valid = vld_q;
	assign rsp_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			// push only happens with the slot empty, so it never meets a move
			if (push) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				vld_q <= 1'b1;
			end else if (rsp_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_data_q <= push_data;
		end
		if (move) begin
			out_data_q <= pend_data_q;
		end
	end

endmodule

FILE: design/ihq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_ctrl: heap sequencer
// Holds the moving record in a register and walks the hole up or down the
// heap, one level per read/compare pair on the record memory.
// ----------------------------------------------------------------------------
module ihq_ctrl import ihq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] req_type,
	input  rec_t       req_rec,
	input  logic       pend_busy,
	output logic       rsp_push,
	output rsp_t       rsp_data,
	output ram_req_t   ram,
	input  rec_t       rd_a,
	input  rec_t       rd_b
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TOP    = 3'd1;
	localparam logic [2:0] S_UP_RD  = 3'd2;
	localparam logic [2:0] S_UP_CMP = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	rec_t              cur_q, cur_d;
	logic              extr_q, extr_d;

	logic              acc;
	logic [IDX_W-1:0]  fill_ext, l_idx, r_idx;
	logic              l_ok, r_ok, big_is_r;
	rec_t              big;
	logic [ADDR_W-1:0] big_addr, par_addr, last_addr;

	assign req_ready = (state_q == S_IDLE) && !pend_busy;
	assign acc       = req_valid && req_ready;

	assign fill_ext  = {{(IDX_W - CNT_W){1'b0}}, fill_q};
	assign l_idx     = {1'b0, pos_q, 1'b1};
	assign r_idx     = l_idx + IDX_W'(1);
	assign l_ok      = l_idx < fill_ext;
	assign r_ok      = r_idx < fill_ext;
	assign big_is_r  = r_ok && (rd_b.key > rd_a.key);
	assign big       = big_is_r ? rd_b : rd_a;
	assign big_addr  = big_is_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
	assign par_addr  = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
	assign last_addr = ADDR_W'(fill_q - CNT_W'(1));

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		pos_d   = pos_q;
		cur_d   = cur_q;
		extr_d  = extr_q;

		rsp_push        = 1'b0;
		rsp_data.status = ST_OK;
		rsp_data.rec    = '0;
		rsp_data.count  = fill_q;

		ram.we      = 1'b0;
		ram.waddr   = pos_q;
		ram.wdata   = cur_q;
		ram.raddr_a = '0;
		ram.raddr_b = last_addr;

		case (state_q)
			S_IDLE: begin
				// root on port a, last entry on port b, ready for S_TOP
				if (acc) begin
					case (req_type)
						REQ_INSERT: begin
							rsp_push = 1'b1;
							if (fill_q >= CNT_W'(CAPACITY)) begin
								rsp_data.status = ST_FULL;
							end else begin
								cur_d          = req_rec;
								pos_d          = ADDR_W'(fill_q);
								fill_d         = fill_q + CNT_W'(1);
								rsp_data.count = fill_q + CNT_W'(1);
								state_d        = S_UP_RD;
							end
						end
						REQ_EXTRACT, REQ_PEEK: begin
							if (fill_q == '0) begin
								rsp_push        = 1'b1;
								rsp_data.status = ST_EMPTY;
							end else begin
								extr_d  = (req_type == REQ_EXTRACT);
								state_d = S_TOP;
							end
						end
						default: begin
							rsp_push = 1'b1;
						end
					endcase
				end
			end
			S_TOP: begin
				rsp_push     = 1'b1;
				rsp_data.rec = rd_a;
				if (extr_q) begin
					rsp_data.count = fill_q - CNT_W'(1);
					fill_d         = fill_q - CNT_W'(1);
					cur_d          = rd_b;
					pos_d          = '0;
					state_d        = (fill_q == CNT_W'(1)) ? S_IDLE : S_DN_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UP_RD: begin
				ram.raddr_a = par_addr;
				if (pos_q == '0) begin
					ram.we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram.we = 1'b1;
				if (cur_q.key > rd_a.key) begin
					// parent moves down into the hole
					ram.wdata = rd_a;
					pos_d     = par_addr;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DN_RD: begin
				ram.raddr_a = l_idx[ADDR_W-1:0];
				ram.raddr_b = r_idx[ADDR_W-1:0];
				if (!l_ok) begin
					ram.we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				ram.we = 1'b1;
				if (big.key > cur_q.key) begin
					// larger child moves up into the hole
					ram.wdata = big;
					pos_d     = big_addr;
					state_d   = S_DN_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		cur_q  <= cur_d;
		extr_q <= extr_d;
	end

endmodule

FILE: design/interval_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_max_heap_queue: binary max-heap of interval records
// Insert, extract-max and peek on a heap of keyed records held in one
// two-read-port record memory.
// ----------------------------------------------------------------------------
//  channel | signals                                            | transfer
//  --------+----------------------------------------------------+-------------------
//  request | req_valid req_ready req_type prio_key point_* value_* | valid & ready
//  result  | rsp_valid rsp_ready status top_* entry_count       | valid & ready
//
// Insert: accept, then per level climbed a parent read followed by a compare and write.
// Extract: read root and last entry, then per level descended read both children,
// compare and write. Peek returns the root read; error cases answer at accept.
// Results leave through a pending slot and an output register.
// Reset clears the entry count and control; the record memory is not cleared.
// A stalled result output blocks a new request only once the pending slot fills.
// ----------------------------------------------------------------------------
module interval_max_heap_queue import ihq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] prio_key,
	input  logic [31:0]        point_left,
	input  logic [31:0]        point_right,
	input  logic [31:0]        value_left,
	input  logic [31:0]        value_right,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [1:0]         status,
	output logic signed [31:0] top_key,
	output logic [31:0]        top_point_left,
	output logic [31:0]        top_point_right,
	output logic [31:0]        top_value_left,
	output logic [31:0]        top_value_right,
	output logic [CNT_W-1:0]   entry_count
);

	rec_t     req_rec;
	ram_req_t ram;
	rec_t     rd_a, rd_b;
	logic     pend_busy, rsp_push;
	rsp_t     push_data, rsp_data;

	assign req_rec.key         = prio_key;
	assign req_rec.point_left  = point_left;
	assign req_rec.point_right = point_right;
	assign req_rec.value_left  = value_left;
	assign req_rec.value_right = value_right;

	ihq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.req_rec   (req_rec),
		.pend_busy (pend_busy),
		.rsp_push  (rsp_push),
		.rsp_data  (push_data),
		.ram       (ram),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	ihq_ram #(
		.DEPTH (CAPACITY),
		.AW    (ADDR_W),
		.W     (REC_W)
	) u_ram (
		.clk     (clk),
		.we      (ram.we),
		.waddr   (ram.waddr),
		.wdata   (ram.wdata),
		.raddr_a (ram.raddr_a),
		.raddr_b (ram.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	ihq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rsp_push),
		.push_data (push_data),
		.pend_busy (pend_busy),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	assign status          = rsp_data.status;
	assign top_key         = rsp_data.rec.key;
	assign top_point_left  = rsp_data.rec.point_left;
	assign top_point_right = rsp_data.rec.point_right;
	assign top_value_left  = rsp_data.rec.value_left;
	assign top_value_right = rsp_data.rec.value_right;
	assign entry_count     = rsp_data.count;

	// every request either starts a sift or fills the pending slot
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on back-to-back cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> entry_count == '0 && top_key == '0)
		else $error("empty result with records or a key");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY) && top_key == '0)
		else $error("full result below capacity");

endmodule
